@@ rtl/core/crbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbt_pkg - shared types and constants
// Item and configuration bundles, register indexes and result codes of the
// retransmission backoff timer.
// ----------------------------------------------------------------------------
package crbt_pkg;

  localparam logic [1:0] CFG_MAX_COUNT    = 2'd0;
  localparam logic [1:0] CFG_MAX_TIME     = 2'd1;
  localparam logic [1:0] CFG_MAX_DURATION = 2'd2;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_RETX   = 2'd1;
  localparam logic [1:0] ACT_FINAL  = 2'd2;
  localparam logic [1:0] ACT_GIVEUP = 2'd3;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam logic [29:0] USEC_PER_SEC    = 30'd1000000;
  localparam logic [29:0] USEC_FIFTH      = 30'd200000;
  localparam logic [29:0] USEC_NINE_TENTH = 30'd900000;
  localparam logic [35:0] DUR_RESET_USEC  = 36'd30000000;
  localparam logic [30:0] DELAY_MAX       = 31'h7fffffff;
  // floor(x / 5) == (x * RECIP5) >> 34 for any 32-bit x
  localparam logic [31:0] RECIP5          = 32'hcccccccd;

  typedef struct packed {
    logic [7:0]  max_count;
    logic [29:0] cap_usec;   // max interval, 0 = no cap
    logic [29:0] cap_base;   // 0.9 * cap
    logic [27:0] cap_fifth;  // cap / 5
    logic [35:0] dur_usec;   // max total duration
  } crbt_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] r16;
    logic [30:0] init;
    logic [28:0] cap_jitter; // r16/65536 * (cap / 5)
  } crbt_item_t;

endpackage

@@ rtl/core/crbt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbt_front - input classification
// Folds the random word, draws the jitter for the capped interval and
// aligns the time stamp to the internal time width.
// ----------------------------------------------------------------------------
module crbt_front #(
  parameter int TIME_BITS = 48
) (
  input  logic                  kind,
  input  logic [47:0]           now_usec,
  input  logic [31:0]           random_word,
  input  logic [30:0]           initial_delay_usec,
  input  crbt_pkg::crbt_cfg_t   cfg,
  output crbt_pkg::crbt_item_t  item,
  output logic [TIME_BITS-1:0]  item_now
);

  logic [63:0] now_wide;
  logic [15:0] r16;
  logic [27:0] jit_hi;
  logic [31:0] jit_lo;

  assign now_wide = {16'd0, now_usec};
  assign item_now = now_wide[TIME_BITS-1:0];

  assign r16    = random_word[15:0] ^ random_word[31:16];
  assign jit_hi = 28'(cfg.cap_fifth[27:16]) * 28'(r16);
  assign jit_lo = 32'(cfg.cap_fifth[15:0]) * 32'(r16);

  always_comb begin
    item.kind       = kind;
    item.r16        = r16;
    item.init       = initial_delay_usec;
    item.cap_jitter = 29'(jit_hi) + 29'(jit_lo[31:16]);
  end

endmodule

@@ rtl/core/crbt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbt_queue - two-entry queue
// Decouples item intake from the backoff sequencer.
// ----------------------------------------------------------------------------
module crbt_queue #(
  parameter int DATA_W = 125
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/crbt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbt_back - backoff sequencer
// Holds the per-request state, steps the delay recurrence (divide, jitter,
// clamp, fire time) and drives the result register.
// ----------------------------------------------------------------------------
module crbt_back #(
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  crbt_pkg::crbt_cfg_t   cfg,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  crbt_pkg::crbt_item_t  q_item,
  input  logic [TIME_BITS-1:0]  q_now,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            action,
  output logic [47:0]           next_fire_usec,
  output logic [30:0]           new_delay_usec,
  output logic [7:0]            send_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_JIT  = 2'd1;
  localparam logic [1:0] ST_DLY  = 2'd2;
  localparam logic [1:0] ST_FIRE = 2'd3;
  localparam logic [64:0] TMAX   = (65'd1 << TIME_BITS) - 65'd1;

  logic [1:0]           st;
  logic [30:0]          prev_delay;
  logic [TIME_BITS-1:0] start_time;
  logic [7:0]           retry_count;

  crbt_pkg::crbt_item_t cur;
  logic [TIME_BITS-1:0] cur_now;
  logic [28:0]          p5;
  logic [29:0]          jit;
  logic [31:0]          base;
  logic [30:0]          delay;

  logic        out_free;
  logic        out_load;
  logic        give_up;
  logic        pop;
  logic [63:0] div_prod;
  logic [28:0] jit_hi;
  logic [31:0] jit_lo;
  logic [32:0] raw;
  logic [30:0] d_sat;
  logic [30:0] delay_next;
  logic [64:0] start_sum;
  logic [64:0] when_sum;
  logic [64:0] limit_sum;
  logic [TIME_BITS-1:0] start_fire;
  logic [TIME_BITS-1:0] when_t;
  logic [TIME_BITS-1:0] limit_t;
  logic        is_final;
  logic [63:0] start_fire_w;
  logic [63:0] fire_w;

  assign out_free = !out_valid || out_ready;
  assign give_up  = (cfg.max_count != 8'd0) && (retry_count >= cfg.max_count);

  always_comb begin
    q_ready = 1'b0;
    if (st == ST_IDLE) begin
      if (q_item.kind == crbt_pkg::KIND_EXPIRY && !give_up) begin
        q_ready = 1'b1;
      end else begin
        q_ready = out_free;
      end
    end
  end
  assign pop = q_valid && q_ready;

  assign out_load = ((st == ST_IDLE) && pop &&
                     (q_item.kind == crbt_pkg::KIND_START || give_up)) ||
                    ((st == ST_FIRE) && out_free);

  assign div_prod = 64'(prev_delay) * 64'(crbt_pkg::RECIP5);
  assign jit_hi   = 29'(p5[28:16]) * 29'(cur.r16);
  assign jit_lo   = 32'(p5[15:0]) * 32'(cur.r16);

  always_comb begin
    raw   = 33'(jit) + 33'(base);
    d_sat = (raw > 33'(crbt_pkg::DELAY_MAX)) ? crbt_pkg::DELAY_MAX : raw[30:0];
    if (cfg.cap_usec != 30'd0 && 31'(d_sat) > 31'(cfg.cap_usec)) begin
      delay_next = 31'(cur.cap_jitter) + 31'(cfg.cap_base);
    end else begin
      delay_next = d_sat;
    end
  end

  always_comb begin
    start_sum  = {1'b0, 64'(q_now)} + {1'b0, 64'(q_item.init)};
    start_fire = (start_sum > TMAX) ? TMAX[TIME_BITS-1:0] : start_sum[TIME_BITS-1:0];
    when_sum   = {1'b0, 64'(cur_now)} + {1'b0, 64'(delay)};
    when_t     = (when_sum > TMAX) ? TMAX[TIME_BITS-1:0] : when_sum[TIME_BITS-1:0];
    limit_sum  = {1'b0, 64'(start_time)} + {1'b0, 64'(cfg.dur_usec)};
    limit_t    = (limit_sum > TMAX) ? TMAX[TIME_BITS-1:0] : limit_sum[TIME_BITS-1:0];
    is_final   = limit_t < when_t;
    start_fire_w = 64'(start_fire);
    fire_w       = is_final ? 64'(limit_t) : 64'(when_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      prev_delay  <= '0;
      start_time  <= '0;
      retry_count <= '0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (pop) begin
            if (q_item.kind == crbt_pkg::KIND_START) begin
              prev_delay     <= q_item.init;
              start_time     <= q_now;
              retry_count    <= '0;
              action         <= crbt_pkg::ACT_START;
              next_fire_usec <= start_fire_w[47:0];
              new_delay_usec <= q_item.init;
              send_count     <= '0;
            end else if (give_up) begin
              action         <= crbt_pkg::ACT_GIVEUP;
              next_fire_usec <= '0;
              new_delay_usec <= '0;
              send_count     <= retry_count;
            end else begin
              cur     <= q_item;
              cur_now <= q_now;
              p5      <= div_prod[62:34];
              st      <= ST_JIT;
            end
          end
        end
        ST_JIT: begin
          jit  <= 30'(jit_hi) + 30'(jit_lo[31:16]);
          base <= {prev_delay, 1'b0} - 32'(p5[28:1]);
          st   <= ST_DLY;
        end
        ST_DLY: begin
          delay <= delay_next;
          st    <= ST_FIRE;
        end
        ST_FIRE: begin
          if (out_free) begin
            prev_delay     <= delay;
            if (retry_count != 8'hff) begin
              retry_count <= retry_count + 8'd1;
              send_count  <= retry_count + 8'd1;
            end else begin
              send_count  <= retry_count;
            end
            action         <= is_final ? crbt_pkg::ACT_FINAL : crbt_pkg::ACT_RETX;
            next_fire_usec <= fire_w[47:0];
            new_delay_usec <= delay;
            st             <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/coa_retransmit_backoff_timer.sv @@
`timescale 1ns / 1ps
// Path: start and give-up beats pass the queue and the result register;
// an expiry beat also passes the sequencer states JIT, DLY and FIRE for the
// delay recurrence (reciprocal divide multiplier, jitter multiplier, clamp,
// fire time adder). Throughput: one start or give-up beat per cycle while
// the result register is free; the sequencer takes no beat until FIRE ends.
// Reset: synchronous; clears timer state and queue, loads register defaults.
// ----------------------------------------------------------------------------
// coa_retransmit_backoff_timer - retransmission backoff timer
// Front stage, two-entry queue and backoff sequencer with a result register.
// ----------------------------------------------------------------------------
module coa_retransmit_backoff_timer #(
  parameter int TIME_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [47:0] now_usec,
  input  logic [31:0] random_word,
  input  logic [30:0] initial_delay_usec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [47:0] next_fire_usec,
  output logic [30:0] new_delay_usec,
  output logic [7:0]  send_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ITEM_W = $bits(crbt_pkg::crbt_item_t);
  localparam int DATA_W = ITEM_W + TIME_BITS;

  crbt_pkg::crbt_cfg_t  cfg;
  crbt_pkg::crbt_item_t f_item;
  crbt_pkg::crbt_item_t q_item;
  logic [TIME_BITS-1:0] f_now;
  logic [TIME_BITS-1:0] q_now;
  logic [DATA_W-1:0]    q_data;
  logic                 q_valid;
  logic                 q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_count <= '0;
      cfg.cap_usec  <= '0;
      cfg.cap_base  <= '0;
      cfg.cap_fifth <= '0;
      cfg.dur_usec  <= crbt_pkg::DUR_RESET_USEC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crbt_pkg::CFG_MAX_COUNT: begin
          cfg.max_count <= cfg_data[7:0];
        end
        crbt_pkg::CFG_MAX_TIME: begin
          cfg.cap_usec  <= 30'(cfg_data[9:0]) * crbt_pkg::USEC_PER_SEC;
          cfg.cap_base  <= 30'(cfg_data[9:0]) * crbt_pkg::USEC_NINE_TENTH;
          cfg.cap_fifth <= 28'(30'(cfg_data[9:0]) * crbt_pkg::USEC_FIFTH);
        end
        crbt_pkg::CFG_MAX_DURATION: begin
          cfg.dur_usec  <= 36'(cfg_data) * 36'(crbt_pkg::USEC_PER_SEC);
        end
        default: begin
        end
      endcase
    end
  end

  crbt_front #(.TIME_BITS(TIME_BITS)) u_front (
    .kind               (kind),
    .now_usec           (now_usec),
    .random_word        (random_word),
    .initial_delay_usec (initial_delay_usec),
    .cfg                (cfg),
    .item               (f_item),
    .item_now           (f_now)
  );

  crbt_queue #(.DATA_W(DATA_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  ({f_item, f_now}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_item = q_data[DATA_W-1:TIME_BITS];
  assign q_now  = q_data[TIME_BITS-1:0];

  crbt_back #(.TIME_BITS(TIME_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .q_now          (q_now),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action         (action),
    .next_fire_usec (next_fire_usec),
    .new_delay_usec (new_delay_usec),
    .send_count     (send_count)
  );

endmodule

@@ rtl/core/crbt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbt_checker - port-level checks
// Result coding and output register behavior seen at the top level ports.
// ----------------------------------------------------------------------------
module crbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  action,
  input logic [47:0] next_fire_usec,
  input logic [30:0] new_delay_usec,
  input logic [7:0]  send_count
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) &&
      $stable(next_fire_usec) && $stable(new_delay_usec) && $stable(send_count))
    else $error("stalled result changed");

  a_start_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == crbt_pkg::ACT_START |-> send_count == 8'd0)
    else $error("start beat with nonzero count");

  a_giveup_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == crbt_pkg::ACT_GIVEUP |->
      next_fire_usec == 48'd0 && new_delay_usec == 31'd0)
    else $error("give-up beat with nonzero time");

  a_retx_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == crbt_pkg::ACT_RETX || action == crbt_pkg::ACT_FINAL) |->
      send_count != 8'd0)
    else $error("retransmit beat with zero count");

endmodule

bind coa_retransmit_backoff_timer crbt_checker u_crbt_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .action         (action),
  .next_fire_usec (next_fire_usec),
  .new_delay_usec (new_delay_usec),
  .send_count     (send_count)
);

@@ sim/crbt_backoff_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbt_backoff_checker - scoreboard for the retransmission backoff timer
// Samples the request, result and register ports on each rising edge. It
// keeps its own copy of the timer state and registers and works out the
// schedule that each accepted request beat should produce. Result beats are
// compared in order against those schedules, field by field.
// ----------------------------------------------------------------------------
module crbt_backoff_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [47:0] now_usec,
  input  logic [31:0] random_word,
  input  logic [30:0] initial_delay_usec,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  action,
  input  logic [47:0] next_fire_usec,
  input  logic [30:0] new_delay_usec,
  input  logic [7:0]  send_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  localparam logic [63:0] TIME_TOP  = 64'hffff_ffff_ffff;
  localparam logic [63:0] WAIT_TOP  = 64'h7fff_ffff;
  localparam logic [63:0] USEC_SEC  = 64'd1000000;

  typedef struct packed {
    logic [1:0]  act;
    logic [47:0] fire;
    logic [30:0] delay;
    logic [7:0]  count;
  } sched_t;

  logic [7:0]  lim_count;
  logic [9:0]  cap_sec;
  logic [15:0] span_sec;
  logic [30:0] prev_wait;
  logic [47:0] t_start;
  logic [7:0]  retries;

  sched_t pending_sched[$];

  function automatic logic [63:0] clamp_time(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > TIME_TOP) ? TIME_TOP : s;
  endfunction

  // r16/65536 * base, split into 16-bit partial products
  function automatic logic [63:0] jitter(logic [63:0] base, logic [15:0] r16);
    return (base >> 16) * 64'(r16) + (((base & 64'hffff) * 64'(r16)) >> 16);
  endfunction

  function automatic sched_t backoff_step(logic k, logic [47:0] t, logic [31:0] w,
                                          logic [30:0] d0);
    sched_t      s;
    logic [15:0] r16;
    logic [63:0] p, d, cap, fire, limit;
    if (k == crbt_pkg::KIND_START) begin
      prev_wait = d0;
      t_start   = t;
      retries   = '0;
      s.act     = crbt_pkg::ACT_START;
      s.fire    = 48'(clamp_time(64'(t), 64'(d0)));
      s.delay   = d0;
      s.count   = '0;
      return s;
    end
    if (lim_count != 0 && retries >= lim_count) begin
      s.act   = crbt_pkg::ACT_GIVEUP;
      s.fire  = '0;
      s.delay = '0;
      s.count = retries;
      return s;
    end
    r16 = w[15:0] ^ w[31:16];
    p   = 64'(prev_wait);
    d   = jitter(p / 5, r16) + 2 * p - p / 10;
    if (d > WAIT_TOP) d = WAIT_TOP;
    cap = 64'(cap_sec) * USEC_SEC;
    if (cap_sec != 0 && d > cap) begin
      d = jitter(cap / 5, r16) + cap - cap / 10;
      if (d > WAIT_TOP) d = WAIT_TOP;
    end
    prev_wait = d[30:0];
    fire  = clamp_time(64'(t), d);
    limit = clamp_time(64'(t_start), 64'(span_sec) * USEC_SEC);
    if (limit < fire) begin
      fire  = limit;
      s.act = crbt_pkg::ACT_FINAL;
    end else begin
      s.act = crbt_pkg::ACT_RETX;
    end
    if (retries != 8'hff) retries = retries + 8'd1;
    s.fire  = fire[47:0];
    s.delay = d[30:0];
    s.count = retries;
    return s;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    sched_t want;
    if (rst) begin
      lim_count = '0;
      cap_sec   = '0;
      span_sec  = 16'd30;
      prev_wait = '0;
      t_start   = '0;
      retries   = '0;
      pending_sched.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          crbt_pkg::CFG_MAX_COUNT:    lim_count = cfg_data[7:0];
          crbt_pkg::CFG_MAX_TIME:     cap_sec   = cfg_data[9:0];
          crbt_pkg::CFG_MAX_DURATION: span_sec  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_sched.size() == 0) begin
          $error("result beat with no schedule pending");
          errors++;
        end else begin
          want = pending_sched.pop_front();
          check_field("action", 64'(want.act), 64'(action));
          check_field("next_fire_usec", 64'(want.fire), 64'(next_fire_usec));
          check_field("new_delay_usec", 64'(want.delay), 64'(new_delay_usec));
          check_field("send_count", 64'(want.count), 64'(send_count));
        end
      end
      if (in_valid && in_ready)
        pending_sched.push_back(backoff_step(kind, now_usec, random_word,
                                             initial_delay_usec));
    end
    outstanding = pending_sched.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - retransmission backoff timer top-level bench
// Drives start and expiry beats in bursts, first a directed set of corner
// cases, then random retry sessions over a series of register settings,
// while the result side stalls in patterns with long hold-offs. A separate
// scoreboard predicts and checks each result.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0]  CFG_SPARE = 2'd3;
  localparam logic [47:0] TIME_END  = 48'hffff_ffff_ffff;
  localparam int RX_FREE  = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [47:0] now_usec;
  logic [31:0] random_word;
  logic [30:0] initial_delay_usec;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  action;
  logic [47:0] next_fire_usec;
  logic [30:0] new_delay_usec;
  logic [7:0]  send_count;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          outstanding;
  int          burst_left;

  coa_retransmit_backoff_timer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .now_usec(now_usec), .random_word(random_word),
    .initial_delay_usec(initial_delay_usec),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .next_fire_usec(next_fire_usec),
    .new_delay_usec(new_delay_usec), .send_count(send_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  crbt_backoff_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .now_usec(now_usec), .random_word(random_word),
    .initial_delay_usec(initial_delay_usec),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .next_fire_usec(next_fire_usec),
    .new_delay_usec(new_delay_usec), .send_count(send_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

  // result side: stall modes switch after runs of random length, with a long
  // hold-off now and then so the timer backs up into its input
  initial begin
    int cyc;
    int mode;
    int mode_left;
    int hold_left;
    out_ready = 1'b0;
    cyc       = 0;
    mode      = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 2500 == 1200) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(RX_FREE, RX_HEAVY);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        case (mode)
          RX_FREE:  out_ready = 1'b1;
          RX_LIGHT: out_ready = ($urandom_range(0, 3) != 0);
          default:  out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [47:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  task automatic put_beat(logic k, logic [47:0] t, logic [31:0] w, logic [30:0] d);
    int gap;
    kind               = k;
    now_usec           = t;
    random_word        = w;
    initial_delay_usec = d;
    in_valid           = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [15:0] value);
    drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // one well-formed retry session: a start, then expiries at non-decreasing times
  task automatic session(int n_exp);
    logic [47:0] t;
    logic [48:0] sum;
    logic [30:0] d;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)      t = 48'($urandom_range(0, 32'h3fff_ffff));
    else if (pick < 9) t = rand_time();
    else               t = TIME_END - 48'($urandom_range(0, 32'h03ff_ffff));
    pick = $urandom_range(0, 19);
    if (pick < 12)      d = 31'($urandom_range(1000, 3_000_000));
    else if (pick < 17) d = 31'($urandom);
    else                d = 31'($urandom_range(0, 100));
    put_beat(crbt_pkg::KIND_START, t, $urandom, d);
    repeat (n_exp) begin
      sum = 49'(t) + 49'($urandom_range(0, 32'h01ff_ffff));
      t   = (sum > 49'(TIME_END)) ? TIME_END : sum[47:0];
      put_beat(crbt_pkg::KIND_EXPIRY, t, $urandom, 31'($urandom));
    end
  endtask

  task automatic run_phase(logic [15:0] cnt, logic [15:0] cap, logic [15:0] span,
                           int beats);
    int n;
    set_reg(crbt_pkg::CFG_MAX_COUNT, cnt);
    set_reg(crbt_pkg::CFG_MAX_TIME, cap);
    set_reg(crbt_pkg::CFG_MAX_DURATION, span);
    while (beats > 0) begin
      if ($urandom_range(0, 99) < 12) begin
        put_beat(1'($urandom_range(0, 1)), rand_time(), $urandom, 31'($urandom));
        beats--;
      end else begin
        n = $urandom_range(0, 12);
        session(n);
        beats -= n + 1;
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    in_valid           = 1'b0;
    kind               = crbt_pkg::KIND_START;
    now_usec           = '0;
    random_word        = '0;
    initial_delay_usec = '0;
    cfg_we             = 1'b0;
    cfg_index          = crbt_pkg::CFG_MAX_COUNT;
    cfg_data           = '0;
    burst_left         = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    // register defaults: no count limit, no cap, 30 s span
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd5, $urandom, 31'd0);
    put_beat(crbt_pkg::KIND_START, 48'd0, 32'd0, 31'd0);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd0, 32'd0, 31'd0);
    put_beat(crbt_pkg::KIND_START, TIME_END, 32'hffff_ffff, crbt_pkg::DELAY_MAX);
    put_beat(crbt_pkg::KIND_EXPIRY, TIME_END, 32'h0000_ffff, crbt_pkg::DELAY_MAX);
    put_beat(crbt_pkg::KIND_START, 48'd1000, 32'd0, 31'd1_000_000);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd1_001_000, 32'h0000_0000, 31'd0);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd3_000_000, 32'hffff_ffff, 31'd0);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd6_000_000, 32'h0000_ffff, 31'd0);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd12_000_000, 32'hffff_0000, 31'd0);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd25_000_000, $urandom, 31'd0);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd31_000_000, $urandom, 31'd0);
    put_beat(crbt_pkg::KIND_START, 48'h8000_0000_0000, $urandom, 31'h4000_0000);

    // small count limit and 1 s cap: cap re-draw, then give up twice
    set_reg(crbt_pkg::CFG_MAX_COUNT, 16'd2);
    set_reg(crbt_pkg::CFG_MAX_TIME, 16'd1);
    set_reg(crbt_pkg::CFG_MAX_DURATION, 16'hffff);
    put_beat(crbt_pkg::KIND_START, 48'd100, $urandom, 31'd900_000);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd1_000_000, $urandom, 31'd0);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd2_500_000, $urandom, 31'd0);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd4_000_000, $urandom, 31'd0);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd5_000_000, $urandom, 31'd0);
    put_beat(crbt_pkg::KIND_START, 48'd50, $urandom, 31'd5);
    put_beat(crbt_pkg::KIND_EXPIRY, 48'd60, $urandom, 31'd0);

    // no limit: one long session drives the retry count into saturation
    set_reg(crbt_pkg::CFG_MAX_COUNT, 16'd0);
    set_reg(crbt_pkg::CFG_MAX_TIME, 16'd0);
    set_reg(crbt_pkg::CFG_MAX_DURATION, 16'd30);
    session(262);
    run_phase(16'd0, 16'd0, 16'd30, 100);
    run_phase(16'd3, 16'd0, 16'd30, 100);
    run_phase(16'd0, 16'd1, 16'd5, 100);
    run_phase(16'd255, 16'd1023, 16'hffff, 100);
    run_phase(16'd0, 16'd1000, 16'd0, 100);
    set_reg(CFG_SPARE, 16'hffff);
    run_phase(16'hff01, 16'hfc07, 16'd120, 100);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 100);

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
